// ----- src/skrt_pkg.sv -----
// skrt_pkg: shared constants, entry type and record check for the sorted keyed record table
// used by sorted_keyed_record_table and skrt_checker
`default_nettype none

package skrt_pkg;

    localparam int CAPACITY = 1024;
    localparam int STATS    = 5;

    localparam int IDX_W   = $clog2(CAPACITY);
    localparam int CNT_W   = 11;
    localparam int KEY_W   = 32;
    localparam int VEC_W   = 40;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 2;

    localparam logic [7:0] QUALITY_MAX = 8'd15;

    localparam logic [CMD_W-1:0] CMD_FIND   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_UPSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_ABSENT  = 2'd1;
    localparam logic [STAT_W-1:0] ST_INVALID = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd3;

    localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VEC_W-1:0] quality;
        logic [VEC_W-1:0] effort;
    } entry_t;

    // bytes of the stat vectors that exist
    function automatic logic [VEC_W-1:0] stat_mask();
        logic [VEC_W-1:0] m;
        m = '0;
        for (int i = 0; i < VEC_W / 8; i++) begin
            if (i < STATS) begin
                m[8*i +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

    function automatic logic record_ok(logic [KEY_W-1:0] key, logic [VEC_W-1:0] q);
        logic ok;
        ok = (key != '0);
        for (int i = 0; i < VEC_W / 8; i++) begin
            if (i < STATS && q[8*i +: 8] > QUALITY_MAX) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

`default_nettype wire

// ----- src/sorted_keyed_record_table.sv -----
// sorted_keyed_record_table: top level, command sequencer around the entry memory
// depends on skrt_pkg and skrt_ram
//
// Usage: the s_ channel takes one command item (find, upsert or remove) with a key
// and, for upsert, the quality and effort byte vectors. The m_ channel returns one
// item per command: status, the stored bytes on a find hit (zero otherwise) and the
// entry count after the command.
// Records sit in one memory, packed in ascending key order in slots 0..count-1.
// Every valid command first scans from slot 0, one entry per cycle, until it meets a key
// at or above the searched key or runs off the end; a find or an upsert hit then answers.
// An insert then moves the larger entries up one slot and a remove moves the later ones
// down, one entry per cycle through the single read port, before they answer. Rejected
// commands (zero key, bad quality byte, unused code) answer without a scan.
// s_ready is high only while no command is in progress; it returns together with the
// result. The result sits in an output register, so the next command can be taken
// and worked on while the receiver stalls; its result then waits until the register
// is free.
// Reset (synchronous, active low) empties the table by zeroing the count.
`default_nettype none

module sorted_keyed_record_table
    import skrt_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [CMD_W-1:0]  s_cmd,
    input  wire logic [KEY_W-1:0]  s_record_key,
    input  wire logic [VEC_W-1:0]  s_quality_bytes,
    input  wire logic [VEC_W-1:0]  s_effort_bytes,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic      [STAT_W-1:0] m_status,
    output logic      [VEC_W-1:0]  m_found_quality,
    output logic      [VEC_W-1:0]  m_found_effort,
    output logic      [CNT_W-1:0]  m_entry_count
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_SHIFT = 3'd2;
    localparam logic [2:0] S_WRNEW = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [CMD_W-1:0]  cmd_reg, cmd_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [VEC_W-1:0]  q_reg, q_next;
    logic [VEC_W-1:0]  e_reg, e_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic              pend_reg, pend_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [IDX_W-1:0]  src_reg, src_next;
    logic [IDX_W-1:0]  dst_reg, dst_next;
    logic              up_reg, up_next;
    logic [STAT_W-1:0] st_reg, st_next;
    logic [VEC_W-1:0]  fq_reg, fq_next;
    logic [VEC_W-1:0]  fe_reg, fe_next;

    logic              m_valid_reg, m_valid_next;
    logic [STAT_W-1:0] m_status_reg, m_status_next;
    logic [VEC_W-1:0]  m_fq_reg, m_fq_next;
    logic [VEC_W-1:0]  m_fe_reg, m_fe_next;
    logic [CNT_W-1:0]  m_count_reg, m_count_next;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    entry_t            ram_wdata;
    logic [IDX_W-1:0]  ram_raddr;
    entry_t            ram_rdata;

    logic              stop_c;
    logic              hit_c;
    logic [CNT_W-1:0]  stop_pos_c;

    skrt_ram #(
        .DEPTH (CAPACITY),
        .WIDTH ($bits(entry_t))
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_ready         = (state_reg == S_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_found_quality = m_fq_reg;
    assign m_found_effort  = m_fe_reg;
    assign m_entry_count   = m_count_reg;

    // scan stops at the first stored key not below the searched key, or at the end
    always_comb begin
        stop_c     = 1'b0;
        hit_c      = 1'b0;
        stop_pos_c = count_reg;
        if (pend_reg && ram_rdata.key >= key_reg) begin
            stop_c     = 1'b1;
            hit_c      = (ram_rdata.key == key_reg);
            stop_pos_c = CNT_W'(idx_reg - CNT_W'(1));
        end else if (idx_reg == count_reg) begin
            stop_c = 1'b1;
        end
    end

    always_comb begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        key_next      = key_reg;
        q_next        = q_reg;
        e_next        = e_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        pend_next     = pend_reg;
        pos_next      = pos_reg;
        rem_next      = rem_reg;
        src_next      = src_reg;
        dst_next      = dst_reg;
        up_next       = up_reg;
        st_next       = st_reg;
        fq_next       = fq_reg;
        fe_next       = fe_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_fq_next     = m_fq_reg;
        m_fe_next     = m_fe_reg;
        m_count_next  = m_count_reg;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        ram_wdata     = '0;
        ram_raddr     = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd_next  = s_cmd;
                    key_next  = s_record_key;
                    q_next    = s_quality_bytes & stat_mask();
                    e_next    = s_effort_bytes & stat_mask();
                    fq_next   = '0;
                    fe_next   = '0;
                    idx_next  = '0;
                    pend_next = 1'b0;
                    if (s_cmd == CMD_UPSERT) begin
                        if (record_ok(s_record_key, s_quality_bytes)) begin
                            state_next = S_SCAN;
                        end else begin
                            st_next    = ST_INVALID;
                            state_next = S_DONE;
                        end
                    end else if ((s_cmd == CMD_FIND || s_cmd == CMD_REMOVE)
                                 && s_record_key != '0) begin
                        state_next = S_SCAN;
                    end else begin
                        st_next    = ST_ABSENT;
                        state_next = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                if (stop_c) begin
                    pend_next  = 1'b0;
                    pos_next   = stop_pos_c;
                    state_next = S_DONE;
                    case (cmd_reg)
                        CMD_FIND: begin
                            if (hit_c) begin
                                st_next = ST_OK;
                                fq_next = ram_rdata.quality;
                                fe_next = ram_rdata.effort;
                            end else begin
                                st_next = ST_ABSENT;
                            end
                        end
                        CMD_UPSERT: begin
                            if (hit_c) begin
                                ram_we    = 1'b1;
                                ram_waddr = stop_pos_c[IDX_W-1:0];
                                ram_wdata = '{key: key_reg, quality: q_reg, effort: e_reg};
                                st_next   = ST_OK;
                            end else if (count_reg >= CAP_COUNT) begin
                                st_next = ST_FULL;
                            end else begin
                                // move slots pos..count-1 up by one, top first
                                rem_next   = CNT_W'(count_reg - stop_pos_c);
                                src_next   = IDX_W'(count_reg - CNT_W'(1));
                                up_next    = 1'b1;
                                state_next = S_SHIFT;
                            end
                        end
                        default: begin
                            if (hit_c) begin
                                // move slots pos+1..count-1 down by one
                                rem_next   = CNT_W'(count_reg - stop_pos_c - CNT_W'(1));
                                src_next   = IDX_W'(stop_pos_c + CNT_W'(1));
                                up_next    = 1'b0;
                                state_next = S_SHIFT;
                            end else begin
                                st_next = ST_ABSENT;
                            end
                        end
                    endcase
                end else begin
                    ram_raddr = idx_reg[IDX_W-1:0];
                    idx_next  = CNT_W'(idx_reg + CNT_W'(1));
                    pend_next = 1'b1;
                end
            end
            S_SHIFT: begin
                // read and write addresses never meet: writes trail the reads
                if (pend_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = dst_reg;
                    ram_wdata = ram_rdata;
                end
                if (rem_reg != '0) begin
                    ram_raddr = src_reg;
                    dst_next  = up_reg ? IDX_W'(src_reg + IDX_W'(1))
                                       : IDX_W'(src_reg - IDX_W'(1));
                    src_next  = up_reg ? IDX_W'(src_reg - IDX_W'(1))
                                       : IDX_W'(src_reg + IDX_W'(1));
                    rem_next  = CNT_W'(rem_reg - CNT_W'(1));
                    pend_next = 1'b1;
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        if (up_reg) begin
                            state_next = S_WRNEW;
                        end else begin
                            count_next = CNT_W'(count_reg - CNT_W'(1));
                            st_next    = ST_OK;
                            state_next = S_DONE;
                        end
                    end
                end
            end
            S_WRNEW: begin
                ram_we     = 1'b1;
                ram_waddr  = pos_reg[IDX_W-1:0];
                ram_wdata  = '{key: key_reg, quality: q_reg, effort: e_reg};
                count_next = CNT_W'(count_reg + CNT_W'(1));
                st_next    = ST_OK;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = st_reg;
                    m_fq_next     = fq_reg;
                    m_fe_next     = fe_reg;
                    m_count_next  = count_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        key_reg      <= key_next;
        q_reg        <= q_next;
        e_reg        <= e_next;
        idx_reg      <= idx_next;
        pos_reg      <= pos_next;
        rem_reg      <= rem_next;
        src_reg      <= src_next;
        dst_reg      <= dst_next;
        up_reg       <= up_next;
        st_reg       <= st_next;
        fq_reg       <= fq_next;
        fe_reg       <= fe_next;
        m_status_reg <= m_status_next;
        m_fq_reg     <= m_fq_next;
        m_fe_reg     <= m_fe_next;
        m_count_reg  <= m_count_next;
    end

endmodule

`default_nettype wire

// ----- src/skrt_ram.sv -----
// skrt_ram: simple dual-port synchronous ram, one write and one registered read per cycle
// no dependencies
`default_nettype none

module skrt_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 112
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- src/skrt_checker.sv -----
// skrt_checker: port-level assertions for sorted_keyed_record_table, bound to the top level
// depends on skrt_pkg
`default_nettype none

module skrt_checker
    import skrt_pkg::*;
(
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_valid,
    input wire logic              s_ready,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire logic [STAT_W-1:0] m_status,
    input wire logic [VEC_W-1:0]  m_found_quality,
    input wire logic [VEC_W-1:0]  m_found_effort,
    input wire logic [CNT_W-1:0]  m_entry_count
);

    // no result item right after reset
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // one command at a time: input closes right after an item is taken
    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input ready right after accept");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_entry_count <= CAP_COUNT))
        else $error("entry count above capacity");

    // payload only on a reply with ok status
    a_payload_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_OK) |-> (m_found_quality == '0 && m_found_effort == '0))
        else $error("payload on a miss");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_status) && $stable(m_entry_count)))
        else $error("result dropped or changed while stalled");

endmodule

bind sorted_keyed_record_table skrt_checker u_skrt_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_status        (m_status),
    .m_found_quality (m_found_quality),
    .m_found_effort  (m_found_effort),
    .m_entry_count   (m_entry_count)
);

`default_nettype wire

// ----- sim/sorted_keyed_record_table_test.sv -----
// sorted_keyed_record_table_test: self-checking bench for the sorted keyed record table
// drives find, upsert and remove commands against a shadow copy of the table held here
// depends on skrt_pkg and sorted_keyed_record_table

module sorted_keyed_record_table_test;
    import skrt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
    localparam int RANDOM_ITEMS = 553;
    localparam int POOL_SIZE    = 40;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_CYCLES  = 600;
    localparam int STALL_LIMIT  = 20000;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [VEC_W-1:0]  quality;
        logic [VEC_W-1:0]  effort;
        logic [CNT_W-1:0]  entries;
    } table_reply_t;

    typedef struct {
        logic [CMD_W-1:0] cmd;
        logic [KEY_W-1:0] key;
        logic [VEC_W-1:0] quality;
        logic [VEC_W-1:0] effort;
        logic             typed;
        table_reply_t     want;
    } table_step_t;

    logic              aclk            = 1'b0;
    logic              aresetn         = 1'b0;
    logic              s_valid         = 1'b0;
    logic              s_ready;
    logic [CMD_W-1:0]  s_cmd           = CMD_FIND;
    logic [KEY_W-1:0]  s_record_key    = '0;
    logic [VEC_W-1:0]  s_quality_bytes = '0;
    logic [VEC_W-1:0]  s_effort_bytes  = '0;
    logic              m_valid;
    logic              m_ready         = 1'b0;
    logic [STAT_W-1:0] m_status;
    logic [VEC_W-1:0]  m_found_quality;
    logic [VEC_W-1:0]  m_found_effort;
    logic [CNT_W-1:0]  m_entry_count;

    // shadow copy of the table, slots 0 .. shadow_count-1 in ascending key order
    logic [KEY_W-1:0] shadow_key [CAPACITY];
    logic [VEC_W-1:0] shadow_quality [CAPACITY];
    logic [VEC_W-1:0] shadow_effort [CAPACITY];
    int               shadow_count = 0;

    table_reply_t pending_replies [$];
    table_step_t  directed_steps [$];

    logic steady       = 1'b0;
    int   mismatches   = 0;
    int   replies_seen = 0;
    int   commands_sent = 0;
    int   peak_count   = 0;
    int   full_seen    = 0;
    int   invalid_seen = 0;

    sorted_keyed_record_table i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_record_key    (s_record_key),
        .s_quality_bytes (s_quality_bytes),
        .s_effort_bytes  (s_effort_bytes),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_found_quality (m_found_quality),
        .m_found_effort  (m_found_effort),
        .m_entry_count   (m_entry_count)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int find_slot(logic [KEY_W-1:0] key);
        if (key == '0) begin
            return -1;
        end
        for (int i = 0; i < shadow_count; i++) begin
            if (shadow_key[i] == key) begin
                return i;
            end
        end
        return -1;
    endfunction

    // applies one command to the shadow table and returns the reply it should give
    function automatic table_reply_t compute_reply(logic [CMD_W-1:0] cmd,
            logic [KEY_W-1:0] key, logic [VEC_W-1:0] q, logic [VEC_W-1:0] e);
        table_reply_t r;
        int           at;
        int           pos;
        logic [VEC_W-1:0] keep;
        logic         legal;
        r = '0;
        r.status = ST_ABSENT;
        at = find_slot(key);
        keep = '0;
        for (int i = 0; i < STATS && i < VEC_W / 8; i++) begin
            keep[8*i +: 8] = 8'hFF;
        end
        case (cmd)
            CMD_FIND: begin
                if (at >= 0) begin
                    r.status  = ST_OK;
                    r.quality = shadow_quality[at];
                    r.effort  = shadow_effort[at];
                end
            end
            CMD_UPSERT: begin
                legal = (key != '0);
                for (int i = 0; i < STATS && i < VEC_W / 8; i++) begin
                    if (q[8*i +: 8] > QUALITY_MAX) begin
                        legal = 1'b0;
                    end
                end
                if (!legal) begin
                    r.status = ST_INVALID;
                end else if (at >= 0) begin
                    shadow_quality[at] = q & keep;
                    shadow_effort[at]  = e & keep;
                    r.status = ST_OK;
                end else if (shadow_count >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    pos = shadow_count;
                    while (pos > 0 && shadow_key[pos-1] > key) begin
                        shadow_key[pos]     = shadow_key[pos-1];
                        shadow_quality[pos] = shadow_quality[pos-1];
                        shadow_effort[pos]  = shadow_effort[pos-1];
                        pos--;
                    end
                    shadow_key[pos]     = key;
                    shadow_quality[pos] = q & keep;
                    shadow_effort[pos]  = e & keep;
                    shadow_count++;
                    r.status = ST_OK;
                end
            end
            CMD_REMOVE: begin
                if (at >= 0) begin
                    for (int i = at; i < shadow_count - 1; i++) begin
                        shadow_key[i]     = shadow_key[i+1];
                        shadow_quality[i] = shadow_quality[i+1];
                        shadow_effort[i]  = shadow_effort[i+1];
                    end
                    shadow_count--;
                    shadow_key[shadow_count]     = '0;
                    shadow_quality[shadow_count] = '0;
                    shadow_effort[shadow_count]  = '0;
                    r.status = ST_OK;
                end
            end
            default: begin
            end
        endcase
        r.entries = CNT_W'(shadow_count);
        return r;
    endfunction

    function automatic logic [VEC_W-1:0] legal_quality();
        logic [VEC_W-1:0] q;
        q = '0;
        for (int i = 0; i < STATS && i < VEC_W / 8; i++) begin
            q[8*i +: 8] = 8'($urandom_range(15));
        end
        return q;
    endfunction

    function automatic logic [VEC_W-1:0] random_vector();
        return VEC_W'({$urandom(), $urandom()});
    endfunction

    task automatic add_step(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
            input logic [VEC_W-1:0] q, input logic [VEC_W-1:0] e, input logic typed,
            input logic [STAT_W-1:0] status, input logic [VEC_W-1:0] fq,
            input logic [VEC_W-1:0] fe, input int entries);
        table_step_t t;
        t.cmd     = cmd;
        t.key     = key;
        t.quality = q;
        t.effort  = e;
        t.typed   = typed;
        t.want    = '{status, fq, fe, CNT_W'(entries)};
        directed_steps.push_back(t);
    endtask

    task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
            input logic [VEC_W-1:0] q, input logic [VEC_W-1:0] e,
            input logic typed = 1'b0, input table_reply_t typed_reply = '0);
        table_reply_t r;
        while (!steady && $urandom_range(99) < 32) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_cmd           <= cmd;
        s_record_key    <= key;
        s_quality_bytes <= q;
        s_effort_bytes  <= e;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        r = compute_reply(cmd, key, q, e);
        pending_replies.push_back(typed ? typed_reply : r);
        commands_sent++;
        if (shadow_count > peak_count) begin
            peak_count = shadow_count;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
            input logic [63:0] want);
        mismatches++;
        if (mismatches <= 30) begin
            $display("reply %0d: %s is %h, expected %h", replies_seen, what, got, want);
        end
    endtask

    // result side: random stalls, one long hold-off, field by field check
    initial begin : receiver
        table_reply_t want;
        int           hold_left;
        logic         hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                if (pending_replies.size() == 0) begin
                    report_mismatch("unexpected item, status", 64'(m_status), 64'(0));
                end else begin
                    want = pending_replies.pop_front();
                    if (m_status !== want.status) begin
                        report_mismatch("status", 64'(m_status), 64'(want.status));
                    end
                    if (m_found_quality !== want.quality) begin
                        report_mismatch("found_quality", 64'(m_found_quality),
                                        64'(want.quality));
                    end
                    if (m_found_effort !== want.effort) begin
                        report_mismatch("found_effort", 64'(m_found_effort),
                                        64'(want.effort));
                    end
                    if (m_entry_count !== want.entries) begin
                        report_mismatch("entry_count", 64'(m_entry_count),
                                        64'(want.entries));
                    end
                    if (want.status == ST_FULL) begin
                        full_seen++;
                    end
                    if (want.status == ST_INVALID) begin
                        invalid_seen++;
                    end
                end
                replies_seen++;
            end
            // hold off long enough for the block to fill its output and stall the input
            if (!hold_done && replies_seen == HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= steady || ($urandom_range(99) >= 32);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("FAILURE");
        $finish;
    end

    initial begin : stimulus
        logic [KEY_W-1:0] key_pool [POOL_SIZE];
        logic [KEY_W-1:0] k;
        logic [KEY_W-1:0] gone;
        logic [VEC_W-1:0] q;
        logic [VEC_W-1:0] e;
        logic [CMD_W-1:0] c;
        int               pick;

        for (int i = 0; i < CAPACITY; i++) begin
            shadow_key[i]     = '0;
            shadow_quality[i] = '0;
            shadow_effort[i]  = '0;
        end

        // directed part on an empty table
        add_step(CMD_FIND,   32'h0000_0000, '0, '0, 1, ST_ABSENT, '0, '0, 0);
        add_step(CMD_FIND,   32'h0000_0001, '0, '0, 1, ST_ABSENT, '0, '0, 0);
        add_step(CMD_REMOVE, 32'h0000_0005, '0, '0, 1, ST_ABSENT, '0, '0, 0);
        add_step(CMD_REMOVE, 32'h0000_0000, '0, '0, 1, ST_ABSENT, '0, '0, 0);
        add_step(CMD_UPSERT, 32'h0000_0000, '0, '0, 1, ST_INVALID, '0, '0, 0);
        add_step(CMD_UPSERT, 32'h0000_0007, 40'h00_0000_0010, '0, 1, ST_INVALID, '0, '0, 0);
        add_step(CMD_UPSERT, 32'h0000_0007, 40'hFF_0000_0000, '0, 1, ST_INVALID, '0, '0, 0);
        add_step(CMD_SPARE,  32'h0000_0007, 40'h01_0203_0405, 40'h1, 0, ST_ABSENT, '0, '0, 0);
        add_step(CMD_UPSERT, 32'hFFFF_FFFF, 40'h0F_0F0F_0F0F, 40'hFF_FFFF_FFFF, 1,
                 ST_OK, '0, '0, 1);
        add_step(CMD_UPSERT, 32'h0000_0001, '0, '0, 1, ST_OK, '0, '0, 2);
        // lands between the two existing keys
        add_step(CMD_UPSERT, 32'h8000_0000, 40'h0F_000F_000F, 40'h5A_A55A_A55A, 1,
                 ST_OK, '0, '0, 3);
        add_step(CMD_FIND,   32'h0000_0001, '0, '0, 1, ST_OK, '0, '0, 3);
        add_step(CMD_FIND,   32'hFFFF_FFFF, '0, '0, 1, ST_OK, 40'h0F_0F0F_0F0F,
                 40'hFF_FFFF_FFFF, 3);
        add_step(CMD_UPSERT, 32'h0000_0001, 40'h0A_0B0C_0D0E, 40'h12_3456_789A, 1,
                 ST_OK, '0, '0, 3);
        add_step(CMD_FIND,   32'h0000_0001, '0, '0, 1, ST_OK, 40'h0A_0B0C_0D0E,
                 40'h12_3456_789A, 3);
        add_step(CMD_FIND,   32'h0000_0002, '0, '0, 1, ST_ABSENT, '0, '0, 3);
        add_step(CMD_UPSERT, 32'h0000_0001, 40'h0A_0B10_0D0E, '0, 1, ST_INVALID, '0, '0, 3);
        add_step(CMD_FIND,   32'h0000_0001, '0, '0, 1, ST_OK, 40'h0A_0B0C_0D0E,
                 40'h12_3456_789A, 3);
        add_step(CMD_REMOVE, 32'h8000_0000, '0, '0, 1, ST_OK, '0, '0, 2);
        add_step(CMD_FIND,   32'h8000_0000, '0, '0, 1, ST_ABSENT, '0, '0, 2);
        add_step(CMD_REMOVE, 32'h0000_0001, '0, '0, 1, ST_OK, '0, '0, 1);
        add_step(CMD_REMOVE, 32'hFFFF_FFFF, '0, '0, 1, ST_OK, '0, '0, 0);
        add_step(CMD_SPARE,  32'h0000_0000, 40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF, 0,
                 ST_ABSENT, '0, '0, 0);

        key_pool[0] = 32'h0000_0001;
        key_pool[1] = 32'hFFFF_FFFF;
        key_pool[2] = 32'h8000_0000;
        for (int i = 3; i < POOL_SIZE; i++) begin
            key_pool[i] = $urandom();
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_steps[i]) begin
            send_command(directed_steps[i].cmd, directed_steps[i].key,
                         directed_steps[i].quality, directed_steps[i].effort,
                         directed_steps[i].typed, directed_steps[i].want);
        end

        // random part on a small table, keys mostly from a fixed pool so hits are common
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            steady = (n >= 250 && n < 350);
            pick = $urandom_range(99);
            k = key_pool[$urandom_range(POOL_SIZE-1)];
            q = random_vector();
            e = random_vector();
            c = CMD_FIND;
            if (pick < 40) begin
                c = CMD_UPSERT;
                q = legal_quality();
            end else if (pick < 60) begin
                c = CMD_FIND;
            end else if (pick < 78) begin
                c = CMD_REMOVE;
            end else if (pick < 84) begin
                c = CMD_UPSERT;
                q = legal_quality();
                q[8*$urandom_range(STATS-1) +: 8] = 8'($urandom_range(255, 16));
            end else if (pick < 88) begin
                c = CMD_UPSERT;
                q = legal_quality();
                k = '0;
            end else if (pick < 92) begin
                c = $urandom_range(1) ? CMD_REMOVE : CMD_FIND;
                k = $urandom();
            end else if (pick < 94) begin
                c = CMD_UPSERT;
                q = legal_quality();
                k = $urandom();
            end else if (pick < 97) begin
                c = CMD_SPARE;
            end else begin
                c = $urandom_range(1) ? CMD_REMOVE : CMD_FIND;
                k = '0;
            end
            send_command(c, k, q, e);
        end
        steady = 1'b0;

        // finish on the smallest stored key: look it up, reject a bad update, remove it
        gone = shadow_key[0];
        send_command(CMD_FIND, gone, random_vector(), random_vector());
        q = legal_quality();
        q[7:0] = 8'hFF;
        send_command(CMD_UPSERT, gone, q, random_vector());
        send_command(CMD_REMOVE, gone, '0, '0);
        send_command(CMD_FIND, gone, '0, '0);
        s_valid <= 1'b0;

        while (pending_replies.size() != 0) begin
            @(posedge aclk);
        end
        // anything that still shows up now is an extra item
        repeat (CAPACITY + 16) @(posedge aclk);

        $display("%0d commands driven and %0d replies checked; table grew to %0d entries",
                 commands_sent, replies_seen, peak_count);
        $display("replies seen: %0d table full, %0d rejected records, %0d mismatches",
                 full_seen, invalid_seen, mismatches);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
